@@ rtl/positional_list_insert_delete_unit_macros.svh @@
// Assertion macros for the positional list unit.
`ifndef POSITIONAL_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PAL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pal_pkg.sv @@
// Shared types and constants of the positional list unit.
`default_nettype none
package pal_pkg;

  localparam int unsigned Capacity    = 16;
  localparam int unsigned MaxCapacity = 64;
  localparam int unsigned IdxW        = $clog2(MaxCapacity);

  localparam int unsigned ReqTypeW  = 2;
  localparam int unsigned PositionW = 8;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned ItemIdxW  = 4;
  localparam int unsigned LengthW   = 5;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_BEYOND = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e            op;
    logic [IdxW-1:0]     at;
    logic [IdxW-1:0]     last;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/pal_req_if.sv @@
// Request channel: request type, position and value.
`default_nettype none
interface pal_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [pal_pkg::ReqTypeW-1:0]         req_type;
  logic [pal_pkg::PositionW-1:0]        position;
  logic signed [pal_pkg::ValueW-1:0]    value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input value,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/pal_rsp_if.sv @@
// Result channel: status, read-out entry, length and end-of-run flag.
`default_nettype none
interface pal_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [pal_pkg::StatusW-1:0]          status;
  logic signed [pal_pkg::ValueW-1:0]    item_value;
  logic [pal_pkg::ItemIdxW-1:0]         item_index;
  logic [pal_pkg::LengthW-1:0]          length;
  logic                                 last_of_run;

  modport source (output valid, output status, output item_value, output item_index,
                  output length, output last_of_run, input ready);
  modport sink   (input valid, input status, input item_value, input item_index,
                  input length, input last_of_run, output ready);
endinterface
`default_nettype wire

@@ rtl/pal_cell.sv @@
// One list cell: holds an entry and shifts with its neighbours.
`default_nettype none
module pal_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire                                  clk_i,
  input  wire pal_pkg::cell_ctrl_t             ctrl_i,
  input  wire logic signed [pal_pkg::ValueW-1:0] ins_value_i,
  input  wire logic signed [pal_pkg::ValueW-1:0] left_i,
  input  wire logic signed [pal_pkg::ValueW-1:0] right_i,
  input  wire logic signed [pal_pkg::ValueW-1:0] head_i,
  output logic signed [pal_pkg::ValueW-1:0]      data_o
);

  localparam logic [pal_pkg::IdxW-1:0] MyIdx = pal_pkg::IdxW'(Idx);

  logic signed [pal_pkg::ValueW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      pal_pkg::CELL_INSERT: begin
        if (MyIdx == ctrl_i.at) begin
          data_d = ins_value_i;
        end else if (MyIdx > ctrl_i.at) begin
          data_d = left_i;
        end
      end
      pal_pkg::CELL_DELETE: begin
        if (MyIdx >= ctrl_i.at) begin
          data_d = right_i;
        end
      end
      pal_pkg::CELL_ROTATE: begin
        // The tail of the live list takes the head back.
        if (MyIdx == ctrl_i.last) begin
          data_d = head_i;
        end else begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

@@ rtl/positional_list_insert_delete_unit.sv @@
// Positional list unit: cell chain holding the list plus request control.
//
// Requests arrive on req_i (valid/ready), results leave on rsp_o through
// an output register. An insert or delete updates the cell chain
// and gives one result with last_of_run set; the next request is taken as
// soon as the output register is free, so with an unstalled receiver one
// request is accepted every cycle. A read-out gives one result per entry,
// one per cycle while the receiver takes them, by rotating the chain once
// around the live entries with the head cell feeding the output; it holds
// req_i off until the last entry is sent. A read-out of an empty list gives
// a single result with the empty status. An insert, a delete or an empty
// read-out registers its result from the request; a read-out of entries
// first enters S_READ. Reset empties the list; cell contents are not
// cleared and are only read below the length. While the receiver stalls,
// the pending result and the chain hold, and no further request is taken.
`default_nettype none
`include "positional_list_insert_delete_unit_macros.svh"
module positional_list_insert_delete_unit #(
  parameter int unsigned CAPACITY = pal_pkg::Capacity
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  pal_req_if.sink   req_i,
  pal_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PW   = pal_pkg::PositionW + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e                      state_q, state_d;
  logic [CntW-1:0]             count_q, count_d;
  logic [pal_pkg::IdxW-1:0]    rd_idx_q, rd_idx_d;

  logic                        out_valid_q, out_valid_d;
  pal_pkg::status_e            out_status_q, out_status_d;
  logic signed [pal_pkg::ValueW-1:0] out_value_q, out_value_d;
  logic [pal_pkg::ItemIdxW-1:0] out_index_q, out_index_d;
  logic [pal_pkg::LengthW-1:0] out_length_q, out_length_d;
  logic                        out_last_q, out_last_d;

  pal_pkg::cell_ctrl_t         ctrl;
  logic signed [pal_pkg::ValueW-1:0] cell_data [CAPACITY];

  logic                        out_free, accept, rd_last;
  logic [PW-1:0]               pos_eff, cnt_ext;
  pal_pkg::status_e            acc_status;
  logic [pal_pkg::IdxW-1:0]    tail_idx;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign accept = req_i.valid && req_i.ready;

  // Position zero behaves as position two.
  assign pos_eff  = (req_i.position == '0) ? PW'(2) : PW'(req_i.position);
  assign cnt_ext  = PW'(count_q);
  assign tail_idx = pal_pkg::IdxW'(count_q - CntW'(1));
  assign rd_last  = (rd_idx_q == tail_idx);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_index_d  = out_index_q;
    out_length_d = out_length_q;
    out_last_d   = out_last_q;
    acc_status   = pal_pkg::ST_OK;
    ctrl.op      = pal_pkg::CELL_HOLD;
    ctrl.at      = pal_pkg::IdxW'(pos_eff - PW'(1));
    ctrl.last    = tail_idx;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            pal_pkg::REQ_INSERT: begin
              if (count_q == '0) begin
                ctrl.op = pal_pkg::CELL_INSERT;
                ctrl.at = '0;
                count_d = CntW'(1);
              end else if (count_q == CntW'(CAPACITY)) begin
                acc_status = pal_pkg::ST_FULL;
              end else if (pos_eff > cnt_ext + PW'(1)) begin
                acc_status = pal_pkg::ST_BEYOND;
              end else begin
                ctrl.op = pal_pkg::CELL_INSERT;
                count_d = count_q + CntW'(1);
              end
            end
            pal_pkg::REQ_DELETE: begin
              if (count_q == '0) begin
                acc_status = pal_pkg::ST_EMPTY;
              end else if (pos_eff > cnt_ext) begin
                acc_status = pal_pkg::ST_BEYOND;
              end else begin
                ctrl.op = pal_pkg::CELL_DELETE;
                count_d = count_q - CntW'(1);
              end
            end
            pal_pkg::REQ_READ: begin
              if (count_q == '0) begin
                acc_status = pal_pkg::ST_EMPTY;
              end
            end
            default: acc_status = pal_pkg::ST_OK;
          endcase

          if (req_i.req_type == pal_pkg::REQ_READ && count_q != '0) begin
            state_d  = S_READ;
            rd_idx_d = '0;
          end else begin
            out_valid_d  = 1'b1;
            out_status_d = acc_status;
            out_value_d  = '0;
            out_index_d  = '0;
            out_length_d = pal_pkg::LengthW'(count_d);
            out_last_d   = 1'b1;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          // Emit the head entry and rotate the live part of the chain.
          ctrl.op      = pal_pkg::CELL_ROTATE;
          out_valid_d  = 1'b1;
          out_status_d = pal_pkg::ST_OK;
          out_value_d  = cell_data[0];
          out_index_d  = pal_pkg::ItemIdxW'(rd_idx_q);
          out_length_d = pal_pkg::LengthW'(count_q);
          out_last_d   = rd_last;
          rd_idx_d     = rd_idx_q + pal_pkg::IdxW'(1);
          if (rd_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_index_q  <= out_index_d;
    out_length_q <= out_length_d;
    out_last_q   <= out_last_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [pal_pkg::ValueW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = req_i.value;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    pal_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .ins_value_i(req_i.value),
      .left_i     (left),
      .right_i    (right),
      .head_i     (cell_data[0]),
      .data_o     (cell_data[i])
    );
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.item_value  = out_value_q;
  assign rsp_o.item_index  = out_index_q;
  assign rsp_o.length      = out_length_q;
  assign rsp_o.last_of_run = out_last_q;

  `PAL_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "list length above capacity")
  `PAL_ASSERT_NEXT(a_stall_holds, out_valid_q && !rsp_o.ready, $stable(count_q) && out_valid_q, "state moved while result stalled")
  `PAL_ASSERT_NEXT(a_read_ends, state_q == S_READ && out_free && rd_last, state_q == S_IDLE && out_last_q, "read-out did not end on last entry")
  `PAL_ASSERT_NEXT(a_read_no_write, state_q == S_READ, $stable(count_q), "length changed during read-out")

endmodule
`default_nettype wire
